[design/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// Types and codes shared by the indexed max-heap and its channel interfaces.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int IdW     = 10;
  localparam int AmountW = 16;
  localparam int TotalW  = 32;
  localparam int EntW    = 9;

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TotalW-1:0] total;
  } hentry_t;

endpackage

[design/imh_if.sv]
// ----------------------------------------------------------------------------
// imh channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface imh_req_if;
  import imh_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [IdW-1:0]     item_id;
  logic [AmountW-1:0] amount;
  modport source (output valid, cmd, item_id, amount, input ready);
  modport sink (input valid, cmd, item_id, amount, output ready);
endinterface

interface imh_rsp_if;
  import imh_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [IdW-1:0]    result_id;
  logic [TotalW-1:0] result_total;
  logic [EntW-1:0]   entries;
  modport source (output valid, status, result_id, result_total, entries, input ready);
  modport sink (input valid, status, result_id, result_total, entries, output ready);
endinterface

[design/indexed_max_heap.sv]
// ----------------------------------------------------------------------------
// indexed_max_heap
// Binary max-heap of (id, total) pairs with an id-to-slot position memory.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | cmd, item_id, amount
//  rsp     | out | status, result_id, result_total, entries
//
//  one command at a time; an add looks up the id's slot and present bit, then
//  updates the entry (saturating sum or new slot) and climbs while it beats its
//  parent; an extract returns the root, moves the last entry to the root and
//  descends while a child is larger; an extract of the last entry or on an
//  empty heap finishes without a descent
//  each heap level costs one memory read and one compare/write
//  an id at or above ID_SPACE is first reduced modulo ID_SPACE
//  after reset a clearing pass empties every present bit,
//  during which req.ready stays low
//  a finished result waits in the rsp register while the next command runs
module indexed_max_heap #(
  parameter int CAPACITY = 256,
  parameter int ID_SPACE = 1024
) (
  input  logic clk,
  input  logic rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);
  import imh_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  // reciprocal of ID_SPACE scaled by 2^20, exact for 10-bit ids
  localparam int RecipM = ((1 << 20) + ID_SPACE - 1) / ID_SPACE;

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_RED  = 14'b00000000000100,
    S_LOOK = 14'b00000000001000,
    S_A1   = 14'b00000000010000,
    S_A2   = 14'b00000000100000,
    S_UPRD = 14'b00000001000000,
    S_UPEV = 14'b00000010000000,
    S_E0   = 14'b00000100000000,
    S_E1   = 14'b00001000000000,
    S_E2   = 14'b00010000000000,
    S_DNRD = 14'b00100000000000,
    S_DNEV = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  // memories
  hentry_t        heap_mem [CAPACITY];
  logic [SW-1:0]  pos_mem  [ID_SPACE];
  logic           pres_mem [ID_SPACE];

  hentry_t        da, db;
  logic [SW-1:0]  pos_q;
  logic           pres_q;

  // registers
  state_t         state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic           cmd_r;
  logic [IdW-1:0] id_r, id_next;
  logic [AmountW-1:0] amt_r;
  logic           k_r, k_next;
  logic [IdW-1:0] q_r, q_next;
  logic [SW-1:0]  s_r, s_next;
  logic [SW-1:0]  p_r, p_next;
  logic [SW-1:0]  l_r, l_next;
  hentry_t        cur, cur_next;
  status_t        res_st, res_st_next;
  logic [IdW-1:0] res_id, res_id_next;
  logic [TotalW-1:0] res_tot, res_tot_next;
  logic [IW-1:0]  clr_idx;
  logic           ovalid;

  // memory port controls
  logic [SW-1:0]  ha_addr, hb_addr, hw_addr;
  logic           hw_en;
  hentry_t        hw_data;
  logic           pw_en;
  logic [IW-1:0]  pw_addr;
  logic [SW-1:0]  pw_data;
  logic           rw_en;
  logic [IW-1:0]  rw_addr;
  logic           rw_data;

  logic [IW-1:0]  idx;
  logic [TotalW:0] sum;
  logic [CW:0]    lchild;
  logic           rv, take_l, take_r;
  logic [TotalW-1:0] bt;
  logic           accept, load;
  logic [29:0]    red_prod;

  assign idx      = IW'(id_r);
  assign accept   = req.valid && req.ready;
  assign load     = (state == S_DONE) && (!ovalid || rsp.ready);
  assign sum      = {1'b0, da.total} + (TotalW+1)'(amt_r);
  assign lchild   = ((CW+1)'(s_r) << 1) + (CW+1)'(1);
  assign rv       = ((CW+1)'(l_r) + (CW+1)'(1)) < (CW+1)'(cnt);
  assign take_l   = da.total > cur.total;
  assign bt       = take_l ? da.total : cur.total;
  assign take_r   = rv && (db.total > bt);
  assign red_prod = 30'(id_r) * 30'(RecipM);

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    id_next      = id_r;
    k_next       = k_r;
    q_next       = q_r;
    s_next       = s_r;
    p_next       = p_r;
    l_next       = l_r;
    cur_next     = cur;
    res_st_next  = res_st;
    res_id_next  = res_id;
    res_tot_next = res_tot;
    ha_addr      = '0;
    hb_addr      = '0;
    hw_en        = 1'b0;
    hw_addr      = s_r;
    hw_data      = cur;
    pw_en        = 1'b0;
    pw_addr      = IW'(cur.id);
    pw_data      = s_r;
    rw_en        = 1'b0;
    rw_addr      = idx;
    rw_data      = 1'b0;
    case (state)
      S_CLR: begin
        rw_en   = 1'b1;
        rw_addr = clr_idx;
        if (clr_idx == IW'(ID_SPACE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          id_next      = req.item_id;
          k_next       = 1'b1;
          res_st_next  = ST_OK;
          res_id_next  = '0;
          res_tot_next = '0;
          if (req.cmd == CMD_EXTRACT) state_next = S_E0;
          else if (32'(req.item_id) >= 32'(ID_SPACE)) state_next = S_RED;
          else state_next = S_LOOK;
        end
      end
      S_RED: begin
        // quotient by reciprocal multiply, then subtract its multiple
        if (k_r) begin
          q_next = IdW'(red_prod >> 20);
          k_next = 1'b0;
        end else begin
          id_next    = id_r - IdW'(32'(q_r) * 32'(ID_SPACE));
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_A1;
      end
      S_A1: begin
        res_id_next = id_r;
        ha_addr     = pos_q;
        if (pres_q) begin
          s_next     = pos_q;
          state_next = S_A2;
        end else if (cnt >= CW'(CAPACITY)) begin
          res_st_next = ST_FULL;
          state_next  = S_DONE;
        end else begin
          cur_next     = '{id: id_r, total: TotalW'(amt_r)};
          res_tot_next = TotalW'(amt_r);
          s_next       = SW'(cnt);
          cnt_next     = cnt + CW'(1);
          rw_en        = 1'b1;
          rw_data      = 1'b1;
          state_next   = S_UPRD;
        end
      end
      S_A2: begin
        cur_next.id    = id_r;
        cur_next.total = sum[TotalW] ? '1 : sum[TotalW-1:0];
        res_tot_next   = cur_next.total;
        state_next     = S_UPRD;
      end
      S_UPRD: begin
        p_next  = SW'((s_r - SW'(1)) >> 1);
        ha_addr = p_next;
        if (s_r == '0) begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UPEV;
        end
      end
      S_UPEV: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
        if (cur.total > da.total) begin
          hw_data    = da;
          pw_addr    = IW'(da.id);
          s_next     = p_r;
          state_next = S_UPRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_E0: begin
        ha_addr = '0;
        if (cnt == '0) begin
          res_st_next = ST_EMPTY;
          state_next  = S_DONE;
        end else begin
          state_next = S_E1;
        end
      end
      S_E1: begin
        res_id_next  = da.id;
        res_tot_next = da.total;
        rw_en        = 1'b1;
        rw_addr      = IW'(da.id);
        cnt_next     = cnt - CW'(1);
        ha_addr      = SW'(cnt_next);
        state_next   = (cnt == CW'(1)) ? S_DONE : S_E2;
      end
      S_E2: begin
        cur_next   = da;
        s_next     = '0;
        state_next = S_DNRD;
      end
      S_DNRD: begin
        l_next  = SW'(lchild);
        ha_addr = SW'(lchild);
        hb_addr = SW'(lchild + (CW+1)'(1));
        if (lchild >= (CW+1)'(cnt)) begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DNEV;
        end
      end
      S_DNEV: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
        if (take_r) begin
          hw_data    = db;
          pw_addr    = IW'(db.id);
          s_next     = SW'((CW+1)'(l_r) + (CW+1)'(1));
          state_next = S_DNRD;
        end else if (take_l) begin
          hw_data    = da;
          pw_addr    = IW'(da.id);
          s_next     = l_r;
          state_next = S_DNRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // heap store: one write, two reads
  always_ff @(posedge clk) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    da <= heap_mem[ha_addr];
    db <= heap_mem[hb_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_q <= pos_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rw_en) pres_mem[rw_addr] <= rw_data;
    pres_q <= pres_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      cnt     <= '0;
      clr_idx <= '0;
      ovalid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_CLR) clr_idx <= clr_idx + IW'(1);
      if (load) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= req.cmd;
      amt_r <= req.amount;
    end
    id_r    <= id_next;
    k_r     <= k_next;
    q_r     <= q_next;
    s_r     <= s_next;
    p_r     <= p_next;
    l_r     <= l_next;
    cur     <= cur_next;
    res_st  <= res_st_next;
    res_id  <= res_id_next;
    res_tot <= res_tot_next;
    if (load) begin
      rsp.status       <= res_st;
      rsp.result_id    <= res_id;
      rsp.result_total <= res_tot;
      rsp.entries      <= EntW'(cnt);
    end
  end

  assign rsp.valid = ovalid;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    load && res_st == ST_FULL |-> cnt == CW'(CAPACITY))
    else $error("full status with free slots");
  a_ext_dec: assert property (@(posedge clk) disable iff (rst)
    state == S_E1 |=> cnt == $past(cnt) - CW'(1))
    else $error("extract did not shrink heap");
  a_add_cmd: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> cmd_r == CMD_ADD)
    else $error("lookup entered on extract");
  a_rst_clr: assert property (@(posedge clk) rst |=> state == S_CLR)
    else $error("reset skipped clearing pass");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the indexed max-heap against a behavioral heap with a position table.
// Directed corner cases, then random add/extract traffic with random stalls.
// ----------------------------------------------------------------------------
import imh_pkg::*;

class heap_scoreboard;
  logic [IdW-1:0]    slot_id [256];
  logic [TotalW-1:0] slot_total [256];
  int unsigned       pos_of [1024];
  bit                present [1024];
  int unsigned       count;
  status_t           exp_status [$];
  logic [IdW-1:0]    exp_id [$];
  logic [TotalW-1:0] exp_total [$];
  logic [EntW-1:0]   exp_entries [$];
  int                errors;

  function new();
    count = 0;
    errors = 0;
    foreach (present[i]) present[i] = 0;
  endfunction

  function void swap_slots(int unsigned a, int unsigned b);
    logic [IdW-1:0] ti;
    logic [TotalW-1:0] tt;
    ti = slot_id[a];
    tt = slot_total[a];
    slot_id[a] = slot_id[b];
    slot_total[a] = slot_total[b];
    slot_id[b] = ti;
    slot_total[b] = tt;
    pos_of[slot_id[a]] = a;
    pos_of[slot_id[b]] = b;
  endfunction

  function void climb(int unsigned s);
    int unsigned p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (slot_total[s] > slot_total[p]) begin
        swap_slots(s, p);
        s = p;
      end else break;
    end
  endfunction

  function void descend(int unsigned s);
    int unsigned best;
    forever begin
      best = s;
      if (2 * s + 1 < count && slot_total[2 * s + 1] > slot_total[best]) best = 2 * s + 1;
      if (2 * s + 2 < count && slot_total[2 * s + 2] > slot_total[best]) best = 2 * s + 2;
      if (best == s) break;
      swap_slots(s, best);
      s = best;
    end
  endfunction

  // note an accepted command and queue the response it must produce
  function void note_command(cmd_t cmd, logic [IdW-1:0] id, logic [AmountW-1:0] amt);
    status_t st;
    logic [IdW-1:0] rid;
    logic [TotalW-1:0] rtot;
    logic [32:0] sum;
    int unsigned s;
    st = ST_OK;
    rid = '0;
    rtot = '0;
    if (cmd == CMD_EXTRACT) begin
      if (count == 0) st = ST_EMPTY;
      else begin
        rid = slot_id[0];
        rtot = slot_total[0];
        present[rid] = 0;
        count--;
        if (count > 0) begin
          slot_id[0] = slot_id[count];
          slot_total[0] = slot_total[count];
          pos_of[slot_id[0]] = 0;
          descend(0);
        end
      end
    end else begin
      rid = id;
      if (present[id]) begin
        s = pos_of[id];
        sum = {1'b0, slot_total[s]} + 33'(amt);
        slot_total[s] = sum[32] ? '1 : sum[31:0];
        rtot = slot_total[s];
        climb(s);
      end else if (count >= 256) st = ST_FULL;
      else begin
        s = count;
        slot_id[s] = id;
        slot_total[s] = TotalW'(amt);
        pos_of[id] = s;
        present[id] = 1;
        count++;
        rtot = TotalW'(amt);
        climb(s);
      end
    end
    exp_status = {exp_status, st};
    exp_id = {exp_id, rid};
    exp_total = {exp_total, rtot};
    exp_entries = {exp_entries, count[EntW-1:0]};
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_response(logic [1:0] st, logic [IdW-1:0] id, logic [TotalW-1:0] tot,
                      logic [EntW-1:0] ent);
    if (exp_status.size() == 0) begin
      report("responses pending", 1, 0);
      return;
    end
    if (st !== exp_status[0]) report("status", st, exp_status[0]);
    if (id !== exp_id[0]) report("result_id", id, exp_id[0]);
    if (tot !== exp_total[0]) report("result_total", tot, exp_total[0]);
    if (ent !== exp_entries[0]) report("entries", ent, exp_entries[0]);
    void'(exp_status.pop_front());
    void'(exp_id.pop_front());
    void'(exp_total.pop_front());
    void'(exp_entries.pop_front());
  endtask
endclass

module tb;
  logic clk;
  logic rst;
  imh_req_if req ();
  imh_rsp_if rsp ();
  heap_scoreboard heap_sb;
  int sent;

  indexed_max_heap dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // valid stays high into the next command when there is no gap
  task send(cmd_t cmd, logic [IdW-1:0] id, logic [AmountW-1:0] amt);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.cmd <= cmd;
    req.item_id <= id;
    req.amount <= amt;
    do @(posedge clk); while (!req.ready);
    heap_sb.note_command(cmd, id, amt);
    sent++;
  endtask

  // response side: random stall per transfer, with stall-free stretches
  initial begin
    int wait_n;
    rsp.ready = 0;
    @(negedge rst);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        rsp.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      rsp.ready <= 1;
      do @(posedge clk); while (!rsp.valid);
      heap_sb.check_response(rsp.status, rsp.result_id, rsp.result_total, rsp.entries);
    end
  end

  initial begin
    int n;
    heap_sb = new();
    sent = 0;
    rst = 1;
    req.valid = 0;
    req.cmd = 0;
    req.item_id = 0;
    req.amount = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed: empty extract, extremes, ties, repeated adds to one id
    send(CMD_EXTRACT, 10'h3FF, 16'hFFFF);
    send(CMD_ADD, 0, 0);
    send(CMD_ADD, 1023, 16'hFFFF);
    send(CMD_ADD, 5, 16'hFFFF);
    send(CMD_ADD, 6, 16'hFFFF);
    send(CMD_EXTRACT, 0, 0);
    send(CMD_EXTRACT, 0, 0);
    send(CMD_EXTRACT, 0, 0);
    send(CMD_EXTRACT, 0, 0);
    send(CMD_EXTRACT, 0, 0);
    send(CMD_ADD, 7, 16'hFFFF);
    for (int i = 0; i < 12; i++) send(CMD_ADD, 7, 16'hFFFF);
    // fill to capacity then overflow with new ids
    for (int i = 0; i < 256; i++) send(CMD_ADD, 10'(i + 100), 16'($urandom_range(0, 65535)));
    send(CMD_ADD, 10'h3FF, 1);
    send(CMD_ADD, 10'h2AA, 2);
    send(CMD_ADD, 7, 5);
    for (int i = 0; i < 256; i++) send(CMD_EXTRACT, 10'($urandom), 16'($urandom));
    send(CMD_EXTRACT, 0, 0);
    // random: small id pool for frequent repeats, occasional wide ids
    for (int i = 0; i < 410; i++) begin
      n = $urandom_range(0, 9);
      if (n < 3) send(CMD_EXTRACT, 10'($urandom), 16'($urandom));
      else if (n < 8) send(CMD_ADD, 10'($urandom_range(0, 40)),
                           16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20)));
      else send(CMD_ADD, 10'($urandom), 16'($urandom));
    end
    req.valid <= 0;
    while (heap_sb.exp_status.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (heap_sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[indexed_max_heap.f]
design/imh_pkg.sv
design/imh_if.sv
design/indexed_max_heap.sv
sim/tb.sv
